/* hdl/assert_macros.svh */
// Assertion macros for the RTL of the hash set block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge of clk, ignored while rst is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never hold at a rising edge of clk, ignored while rst is high.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

/* hdl/hsi_pkg.sv */
// Types and constants of the linear-probing hash set.
`default_nettype none

package hsi_pkg;

  localparam int KEY_W      = 64;
  localparam int CFG_W      = 4;
  localparam int STATUS_W   = 2;
  localparam int HASH_SHIFT = 29;

  localparam logic [CFG_W-1:0] SIZE_LOG2_RESET = 4'd10;

  localparam logic [STATUS_W-1:0] STATUS_INSERTED = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_PRESENT  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK
  } state_t;

endpackage

`default_nettype wire

/* hdl/hsi_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module hsi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hdl/hash_set_insert_linear_probe.sv */
// Linear-probing hash set of 64-bit keys: one status per inserted key.
// An item is taken only in the idle state. Its home slot and then the next slots are read and
// compared one per cycle, up to 2**size_log2 slots (size 0 counts as 1, capped at the table
// depth). The next item is taken only after the result is loaded, which waits on out_stall.
// After reset the slot RAM is swept to clear the used marks; no item is taken during the sweep,
// though configuration writes are.
`default_nettype none

module hash_set_insert_linear_probe #(
  parameter int TABLE_DEPTH = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write_en,
  input  wire logic [hsi_pkg::CFG_W-1:0]     cfg_write_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [hsi_pkg::KEY_W-1:0]     key,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [hsi_pkg::STATUS_W-1:0]  status
);

  import hsi_pkg::*;
  `include "assert_macros.svh"

  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int LG_MAX = $clog2(TABLE_DEPTH + 1) - 1;
  localparam int RAM_W  = KEY_W + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  state_t              state, state_next;
  logic [CFG_W-1:0]    size_log2;
  logic [IDX_W-1:0]    idx, idx_next;
  logic [IDX_W-1:0]    probe, probe_next;
  logic [KEY_W-1:0]    key_held;

  logic [CFG_W-1:0]    lg_eff;
  logic [IDX_W:0]      slot_count;
  logic [IDX_W-1:0]    mask;
  logic [IDX_W-1:0]    home;
  logic [IDX_W-1:0]    idx_inc;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [RAM_W-1:0]    ram_wdata;
  logic [IDX_W-1:0]    ram_raddr;
  logic [RAM_W-1:0]    ram_rdata;

  logic                slot_used;
  logic                key_match;
  logic                done;
  logic                out_free;
  logic                load;
  logic [STATUS_W-1:0] result;

  // Slot count: the register clamped to at least two slots and to the table depth.
  always_comb begin
    lg_eff = size_log2;
    if (size_log2 == '0) begin
      lg_eff = CFG_W'(1);
    end else if (int'(size_log2) > LG_MAX) begin
      lg_eff = CFG_W'(LG_MAX);
    end
  end

  assign slot_count = (IDX_W + 1)'(1) << lg_eff;
  assign mask       = IDX_W'(slot_count - (IDX_W + 1)'(1));
  assign home       = (key[IDX_W-1:0] ^ key[HASH_SHIFT +: IDX_W]) & mask;
  assign idx_inc    = (idx + IDX_W'(1)) & mask;

  assign slot_used = ram_rdata[KEY_W];
  assign key_match = ram_rdata[KEY_W-1:0] == key_held;
  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = state != S_IDLE;

  always_comb begin
    state_next = state;
    idx_next   = idx;
    probe_next = probe;
    ram_we     = 1'b0;
    ram_waddr  = idx;
    ram_wdata  = {1'b1, key_held};
    ram_raddr  = home;
    done       = 1'b0;
    load       = 1'b0;
    result     = STATUS_INSERTED;
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = {1'b0, key_held};
        idx_next  = idx + IDX_W'(1);
        if (idx == LAST_IDX) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        // The home slot is read in the cycle the item is taken.
        ram_raddr = home;
        if (in_valid) begin
          idx_next   = home;
          probe_next = '0;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!slot_used) begin
          done   = 1'b1;
          result = STATUS_INSERTED;
        end else if (key_match) begin
          done   = 1'b1;
          result = STATUS_PRESENT;
        end else if (probe == mask) begin
          done   = 1'b1;
          result = STATUS_FULL;
        end
        if (done) begin
          // Re-read the same slot while the result cannot yet be handed on.
          ram_raddr = idx;
          if (out_free) begin
            load       = 1'b1;
            ram_we     = !slot_used;
            state_next = S_IDLE;
          end
        end else begin
          ram_raddr  = idx_inc;
          idx_next   = idx_inc;
          probe_next = probe + IDX_W'(1);
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      idx       <= '0;
      probe     <= '0;
      size_log2 <= SIZE_LOG2_RESET;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      idx       <= idx_next;
      probe     <= probe_next;
      out_valid <= load || (out_valid && out_stall);
      if (cfg_write_en) begin
        size_log2 <= cfg_write_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      key_held <= key;
    end
    if (load) begin
      status <= result;
    end
  end

  hsi_ram #(
    .WIDTH(RAM_W),
    .DEPTH(TABLE_DEPTH)
  ) u_slots (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  `ASSERT_NEVER(a_no_result_in_clear, state == S_CLEAR && out_valid, "result during clear sweep")
  `ASSERT_CLK(a_probe_in_range, state == S_CHECK |-> probe <= mask, "probe count beyond slot count")
  `ASSERT_CLK(a_result_from_check, $rose(out_valid) |-> $past(state) == S_CHECK,
              "result not from a probe")
  `ASSERT_CLK(a_write_only_on_insert, (state == S_CHECK && ram_we) |-> !slot_used && load,
              "slot written without insert")

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the linear-probing hash set insert block.
module tb_top;
  import hsi_pkg::*;

  localparam int TABLE_DEPTH     = 1024;
  localparam int DEPTH_LOG2      = $clog2(TABLE_DEPTH);
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int PHASES          = 10;
  localparam int PHASE_ITEMS     = 40;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [STATUS_W-1:0] status;
  } insert_outcome_t;

  logic                clk            = 1'b0;
  logic                rst            = 1'b1;
  logic                cfg_write_en   = 1'b0;
  logic [CFG_W-1:0]    cfg_write_data = '0;
  logic                in_valid       = 1'b0;
  logic                in_stall;
  logic [KEY_W-1:0]    key            = '0;
  logic                out_valid;
  logic                out_stall      = 1'b0;
  logic [STATUS_W-1:0] status;

  // Shadow copy of the set, kept in step with every item the block takes.
  bit                  slot_used_shadow [TABLE_DEPTH];
  logic [KEY_W-1:0]    slot_key_shadow  [TABLE_DEPTH];
  logic [CFG_W-1:0]    size_log2_shadow;
  insert_outcome_t     awaited_outcomes[$];
  insert_outcome_t     oldest_outcome;
  logic [KEY_W-1:0]    sent_keys[$];
  int unsigned         mismatch_count = 0;
  int unsigned         hold_cycles    = 0;
  bit                  no_idle        = 1'b0;

  always #6 clk = ~clk;

  hash_set_insert_linear_probe #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .key           (key),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status)
  );

  task automatic report_mismatch(input string what);
    if (mismatch_count < 200) begin
      $display("%0t: mismatch: %s", $time, what);
    end
    mismatch_count++;
  endtask

  // Probes the shadow table exactly as the block should and updates it.
  function automatic logic [STATUS_W-1:0] predict_insert(input logic [KEY_W-1:0] k);
    int unsigned lg;
    int unsigned slots;
    int unsigned idx;
    logic [KEY_W-1:0] hashed;
    lg = (size_log2_shadow == 0) ? 1 : size_log2_shadow;
    if (lg > DEPTH_LOG2) begin
      lg = DEPTH_LOG2;
    end
    slots  = 1 << lg;
    hashed = k ^ (k >> HASH_SHIFT);
    idx    = hashed[31:0] & (slots - 1);
    for (int unsigned probe = 0; probe < slots; probe++) begin
      if (!slot_used_shadow[idx]) begin
        slot_used_shadow[idx] = 1'b1;
        slot_key_shadow[idx]  = k;
        return STATUS_INSERTED;
      end
      if (slot_key_shadow[idx] == k) begin
        return STATUS_PRESENT;
      end
      idx = (idx + 1) & (slots - 1);
    end
    return STATUS_FULL;
  endfunction

  // Everything is sampled at the rising edge, before the edge's own updates land.
  always @(posedge clk) begin
    if (rst) begin
      slot_used_shadow = '{default: 1'b0};
      size_log2_shadow = SIZE_LOG2_RESET;
      awaited_outcomes.delete();
    end else begin
      if (cfg_write_en) begin
        size_log2_shadow = cfg_write_data;
      end
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (awaited_outcomes.size() == 0) begin
          report_mismatch($sformatf("status %0d with no item outstanding", status));
        end else begin
          oldest_outcome = awaited_outcomes.pop_front();
          if (status !== oldest_outcome.status) begin
            report_mismatch($sformatf("key %h: status %0d, expected %0d",
                                      oldest_outcome.key, status, oldest_outcome.status));
          end
        end
      end
      if (in_valid === 1'b1 && in_stall === 1'b0) begin
        awaited_outcomes.push_back('{key: key, status: predict_insert(key)});
      end
    end
  end

  // Result side: random stalls, a quiet stretch, and a long hold-off on request.
  always @(posedge clk) begin
    if (hold_cycles != 0) begin
      out_stall   <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else if (no_idle) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 26);
    end
  end

  task automatic send_key(input logic [KEY_W-1:0] k);
    if (!no_idle) begin
      while ($urandom_range(0, 99) < 26) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    key      <= k;
    do @(posedge clk); while (in_stall !== 1'b0);
    sent_keys.push_back(k);
  endtask

  task automatic drain_outcomes();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_outcomes.size() != 0);
    @(posedge clk);
  endtask

  task automatic resize_table(input logic [CFG_W-1:0] size_log2);
    drain_outcomes();
    cfg_write_data <= size_log2;
    cfg_write_en   <= 1'b1;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    @(posedge clk);
  endtask

  // Mix of repeats, full-width random keys and keys that pile onto a few home slots.
  function automatic logic [KEY_W-1:0] random_key();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 35 && sent_keys.size() != 0) begin
      return sent_keys[$urandom_range(0, sent_keys.size() - 1)];
    end else if (pick < 70) begin
      return {$urandom, $urandom};
    end
    return KEY_W'($urandom_range(0, 31)) + (KEY_W'($urandom_range(0, 255)) << 10);
  endfunction

  task automatic test_basic_inserts();
    send_key('0);
    send_key('1);
    send_key('0);
    send_key('1);
    send_key(64'h8000_0000_0000_0000);
    send_key(64'h0000_0000_2000_0000);
    // Three keys share home slot 5 and form a chain; slot 6 then gets displaced.
    send_key(64'd5);
    send_key(64'd5 + 64'd1024);
    send_key(64'd5 + 64'd2048);
    send_key(64'd6);
    send_key(64'd5 + 64'd1024);
    send_key(64'hA5A5_5A5A_F0F0_0F0F);
  endtask

  task automatic test_size_extremes();
    // A size of zero behaves as two slots, both already taken.
    resize_table(4'd0);
    send_key('0);
    send_key(64'h0000_0000_2000_0000);
    send_key(64'd7);
    send_key('1);
    // Oversized values saturate at the full table.
    resize_table(4'd15);
    send_key(64'd5 + 64'd2048);
    send_key(64'd9);
    resize_table(4'd1);
    send_key(64'h0123_4567_89AB_CDEF);
    resize_table(4'd11);
    send_key(64'd6);
    resize_table(4'd3);
    send_key(64'd100);
    send_key(64'd101);
    send_key(64'd102);
    send_key(64'd103);
    resize_table(4'd10);
    send_key('0);
    send_key(64'h0123_4567_89AB_CDEF);
  endtask

  task automatic test_random_phases();
    logic [CFG_W-1:0] sizes [3] = '{4'd2, 4'd10, 4'd0};
    for (int phase = 0; phase < PHASES; phase++) begin
      resize_table(phase < 3 ? sizes[phase] : CFG_W'($urandom_range(0, 15)));
      repeat (PHASE_ITEMS) send_key(random_key());
    end
  endtask

  task automatic test_no_idle();
    resize_table(4'd10);
    no_idle <= 1'b1;
    repeat (50) send_key(random_key());
    drain_outcomes();
    no_idle <= 1'b0;
  endtask

  task automatic test_hold_off();
    drain_outcomes();
    hold_cycles <= HOLD_OFF_CYCLES;
    repeat (20) send_key(random_key());
    drain_outcomes();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_basic_inserts();
    test_size_extremes();
    test_random_phases();
    test_no_idle();
    test_hold_off();
    drain_outcomes();
    repeat (TABLE_DEPTH + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
